FILE: rtl/core/tsock_pkg.sv
// Shared types, constants and helpers for the TSO IPv4/TCP checksum block.
// Used by the input stage, the checksum core and the top level.
package tsock_pkg;

    localparam int MAX_PACKET_WORDS = 32768;
    localparam int POS_W            = $clog2(MAX_PACKET_WORDS);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_WORDS - 1);

    localparam logic [POS_W-1:0] POS_TOTAL_LEN = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PROTO     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_IP_CSUM   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ADDR_LO   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_ADDR_HI   = POS_W'(9);
    localparam logic [15:0]      TCP_CSUM_OFS  = 16'd8;

    localparam logic [15:0] HI_BYTE = 16'hff00;
    localparam logic [15:0] LO_BYTE = 16'h00ff;

    typedef struct packed {
        logic [15:0] data;
        logic        first;
        logic        last;
        logic        odd;
        logic [4:0]  hdr_words;
        logic [15:0] l4_len;
        logic [15:0] total_len;
    } t_item;

    typedef struct packed {
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
        logic [15:0] total_len;
    } t_result;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: rtl/core/tso_ipv4_tcp_checksum_offload.sv
// Top level of the TSO IPv4/TCP checksum block: input stage, sum core, result register.
// Depends on tsock_pkg, tsock_in_stage and tsock_sum_core.
//
// One packet word is taken per clock cycle while o_stall is low, back to back, with
// no gaps between segments. A word passes the input register and is then added into
// the running IP and TCP sums; on the last word of a segment the checksums and total
// length are captured in the result register at the edge that adds that word, and
// o_valid rises with that capture. The running sums are updated by each word as it
// fires. Input stall is raised only while a finished result waits on a stalled
// output and another last word is ready behind it.
module tso_ipv4_tcp_checksum_offload (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_data_word,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic        i_last_is_odd,
    input  logic [5:0]  i_ip_header_bytes,
    input  logic [5:0]  i_tcp_header_bytes,
    input  logic [15:0] i_payload_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ip_checksum,
    output logic [15:0] o_tcp_checksum,
    output logic [15:0] o_new_total_length
);
    import tsock_pkg::*;

    logic    in_valid;
    t_item   in_item;
    t_result result;
    logic    out_free;
    logic    fire;
    logic    load;
    logic    r_out_valid;
    t_result r_out;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = in_valid && (out_free || !in_item.last);
    assign o_stall  = in_valid && !fire;
    assign load     = i_valid && !o_stall;

    tsock_in_stage u_in (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_fire             (fire),
        .i_data_word        (i_data_word),
        .i_first_word       (i_first_word),
        .i_last_word        (i_last_word),
        .i_last_is_odd      (i_last_is_odd),
        .i_ip_header_bytes  (i_ip_header_bytes),
        .i_tcp_header_bytes (i_tcp_header_bytes),
        .i_payload_bytes    (i_payload_bytes),
        .o_valid            (in_valid),
        .o_item             (in_item)
    );

    tsock_sum_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && in_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && in_item.last) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_ip_checksum      = r_out.ip_csum;
    assign o_tcp_checksum     = r_out.tcp_csum;
    assign o_new_total_length = r_out.total_len;

endmodule

FILE: rtl/core/tsock_in_stage.sv
// Input register of the checksum block; precomputes the segment lengths.
// Depends on tsock_pkg.
module tsock_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_fire,
    input  logic [15:0]     i_data_word,
    input  logic            i_first_word,
    input  logic            i_last_word,
    input  logic            i_last_is_odd,
    input  logic [5:0]      i_ip_header_bytes,
    input  logic [5:0]      i_tcp_header_bytes,
    input  logic [15:0]     i_payload_bytes,
    output logic            o_valid,
    output tsock_pkg::t_item o_item
);
    import tsock_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [15:0] l4_len;

    always_comb begin
        l4_len              = {10'd0, i_tcp_header_bytes} + i_payload_bytes;
        n_item.data         = i_data_word;
        n_item.first        = i_first_word;
        n_item.last         = i_last_word;
        n_item.odd          = i_last_is_odd;
        n_item.hdr_words    = i_ip_header_bytes[5:1];
        n_item.l4_len       = l4_len;
        n_item.total_len    = {10'd0, i_ip_header_bytes} + l4_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/tsock_sum_core.sv
// Running ones' complement sums, word position and latched lengths.
// Depends on tsock_pkg; result is combinational, registered by the top level.
module tsock_sum_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tsock_pkg::t_item   i_item,
    output tsock_pkg::t_result o_result
);
    import tsock_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_ip_sum;
    logic [15:0]      r_tcp_sum;
    logic [4:0]       r_hdr_words;
    logic [15:0]      r_l4_len;
    logic [15:0]      r_total_len;

    logic [POS_W-1:0] pos;
    logic [4:0]       hdr_words;
    logic [15:0]      l4_len;
    logic [15:0]      total_len;
    logic [15:0]      ip_base;
    logic [15:0]      tcp_base;
    logic [15:0]      word;
    logic             in_ip;
    logic [15:0]      pseudo;
    logic [15:0]      n_ip_sum;
    logic [15:0]      n_tcp_sum;
    logic [POS_W-1:0] n_pos;

    always_comb begin
        pos       = i_item.first ? '0 : r_pos;
        hdr_words = i_item.first ? i_item.hdr_words : r_hdr_words;
        l4_len    = i_item.first ? i_item.l4_len : r_l4_len;
        total_len = i_item.first ? i_item.total_len : r_total_len;
        ip_base   = i_item.first ? 16'd0 : r_ip_sum;
        tcp_base  = i_item.first ? i_item.l4_len : r_tcp_sum;

        word = i_item.data;
        if (pos == POS_TOTAL_LEN) begin
            word = total_len;
        end
        if (pos == POS_IP_CSUM || 16'(pos) == {11'd0, hdr_words} + TCP_CSUM_OFS) begin
            word = 16'd0;
        end
        if (i_item.last && i_item.odd) begin
            word = word & HI_BYTE;
        end

        in_ip = {{(POS_W > 5 ? POS_W - 5 : 0){1'b0}}, hdr_words} > 32'(pos);

        if (pos == POS_PROTO) begin
            pseudo = word & LO_BYTE;
        end else if (pos >= POS_ADDR_LO && pos <= POS_ADDR_HI) begin
            pseudo = word;
        end else begin
            pseudo = 16'd0;
        end

        n_ip_sum  = oc_add(ip_base, in_ip ? word : 16'd0);
        n_tcp_sum = oc_add(oc_add(tcp_base, in_ip ? 16'd0 : word), pseudo);
        n_pos     = (pos < POS_MAX) ? pos + POS_W'(1) : pos;

        o_result.ip_csum   = ~n_ip_sum;
        o_result.tcp_csum  = ~n_tcp_sum;
        o_result.total_len = total_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_ip_sum    <= '0;
            r_tcp_sum   <= '0;
            r_hdr_words <= '0;
            r_l4_len    <= '0;
            r_total_len <= '0;
        end else if (i_fire) begin
            r_hdr_words <= hdr_words;
            r_l4_len    <= l4_len;
            r_total_len <= total_len;
            if (i_item.last) begin
                r_pos     <= '0;
                r_ip_sum  <= '0;
                r_tcp_sum <= '0;
            end else begin
                r_pos     <= n_pos;
                r_ip_sum  <= n_ip_sum;
                r_tcp_sum <= n_tcp_sum;
            end
        end
    end

endmodule

FILE: rtl/core/tsock_checker.sv
// Port-level checker for the TSO IPv4/TCP checksum block, bound to the top level.
// Depends only on the top level's ports.
module tsock_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [15:0] i_data_word,
    input logic        i_first_word,
    input logic        i_last_word,
    input logic        i_last_is_odd,
    input logic [5:0]  i_ip_header_bytes,
    input logic [5:0]  i_tcp_header_bytes,
    input logic [15:0] i_payload_bytes,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_ip_checksum,
    input logic [15:0] o_tcp_checksum,
    input logic [15:0] o_new_total_length
);

    logic        one_word;
    logic [15:0] one_word_len;

    assign one_word     = i_valid && !o_stall && i_first_word && i_last_word;
    assign one_word_len = {10'd0, i_ip_header_bytes} + {10'd0, i_tcp_header_bytes}
                          + i_payload_bytes;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output is free");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ip_checksum)
            && $stable(o_tcp_checksum) && $stable(o_new_total_length))
        else $error("stalled result changed");

    a_one_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        one_word ##1 (!o_valid || !i_stall) |=> o_valid
            && o_new_total_length == $past(one_word_len, 2))
        else $error("wrong total length for one-word segment");

endmodule

bind tso_ipv4_tcp_checksum_offload tsock_checker u_tsock_checker (.*);
